/* hw/rtl/nsdq_pkg.sv */
`timescale 1ns / 1ps
// Package with the widths, constants and register indexes of the noise-shaped dither quantizer.
package nsdq_pkg;

   localparam int NoiseStages  = 16;
   localparam int FractionBits = 24;
   localparam int StageIdxW    = (NoiseStages > 1) ? $clog2(NoiseStages) : 1;

   localparam int SampleW    = 32;
   localparam int LevelW     = 25;
   localparam int ScaleW     = 48;
   localparam int ScaleHalfW = ScaleW / 2;
   localparam int InvScaleW  = 30;
   localparam int SeedW      = 32;
   localparam int CsrIndexW  = 2;
   localparam int CsrDataW   = 48;

   localparam int ScaleShift = (SampleW - 1) + ScaleHalfW - FractionBits;
   localparam int ScaleHiW   = SampleW + ScaleHalfW + 1;
   localparam int ScaleAccW  = SampleW + ScaleW + 1;
   localparam int XW         = FractionBits + 26;
   localparam int StageW     = 32;
   localparam int ShaperW    = FractionBits + 4;
   localparam int ErrW       = FractionBits + 5;
   localparam int TermSumW   = FractionBits + 12;
   localparam int SumW       = XW + 2;
   localparam int LevelRawW  = SumW - FractionBits;
   localparam int SqW        = FractionBits + 7;
   localparam int CubeW      = FractionBits + 10;
   localparam int MulAW      = (CubeW > SampleW) ? CubeW : SampleW;
   localparam int MulBW      = (SqW > InvScaleW + 1) ? SqW : InvScaleW + 1;
   localparam int ProdW      = MulAW + MulBW;
   localparam int ScaledW    = ProdW - 1;

   localparam logic signed [FractionBits+1:0] K097 =
      (FractionBits + 2)'((64'd97 << FractionBits) / 64'd100);
   localparam logic signed [FractionBits+1:0] K0475 =
      (FractionBits + 2)'((64'd19 << FractionBits) / 64'd40);

   localparam logic [SeedW-1:0]     SeedDefault   = 32'd2463534242;
   localparam logic [ScaleW-1:0]    ScaleReset    = 48'd549755813888;
   localparam logic [InvScaleW-1:0] InvScaleReset = 30'd131072;

   localparam logic [CsrIndexW-1:0] CsrScale    = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrInvScale = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrSeed     = 2'd2;

endpackage

/* hw/rtl/noise_shaped_dither_quantizer_unit.sv */
`timescale 1ns / 1ps
// Noise-shaped dither quantizer: one sample in, one floored level and rescaled sample out.
// The unit takes one sample beat at a time and returns one result beat for it; a new
// sample is taken only after the previous one has finished its steps. The steps share
// one signed 34 x 31 multiplier, used by the two halves of the input gain, the cubic
// softening, the shaper mix and the output rescale, and run the noise cascade, which
// updates one stage per cycle. A finished result waits in an output register, so the
// unit goes on with the next sample while the result beat is pending. Registers are to
// be written through the csr port only while the unit is idle; the unit itself does not
// enforce this. A write of the seed reloads the generator at once, and a zero seed loads
// the default seed.
module noise_shaped_dither_quantizer_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [nsdq_pkg::SampleW-1:0]       req_sample_in,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [nsdq_pkg::LevelW-1:0]        rsp_level,
   output logic signed [nsdq_pkg::SampleW-1:0]       rsp_sample_out,
   input  logic                                      csr_we,
   input  logic [nsdq_pkg::CsrIndexW-1:0]            csr_index,
   input  logic [nsdq_pkg::CsrDataW-1:0]             csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE_HI,
      ST_SCALE_LO,
      ST_SCALE_SUM,
      ST_DITHER,
      ST_ADJUST,
      ST_SQUARE,
      ST_CUBE,
      ST_SOFTEN,
      ST_SHAPER,
      ST_MIX,
      ST_ACCUM,
      ST_LEVEL,
      ST_RESCALE,
      ST_DONE
   } state_type;

   function automatic logic [nsdq_pkg::SeedW-1:0] rng_step(input logic [nsdq_pkg::SeedW-1:0] w);
      logic [nsdq_pkg::SeedW-1:0] r;
      r = w ^ (w << 13);
      r = r ^ (r >> 17);
      r = r ^ (r << 5);
      return r;
   endfunction

   function automatic logic signed [nsdq_pkg::StageW-1:0] rng_draw(
      input logic [nsdq_pkg::SeedW-1:0] w);
      logic signed [nsdq_pkg::FractionBits-1:0] d;
      d = {~w[nsdq_pkg::SeedW-1], w[nsdq_pkg::SeedW-2 -: nsdq_pkg::FractionBits-1]};
      return nsdq_pkg::StageW'(d);
   endfunction

   state_type                                  state_ff, state_in;
   logic [nsdq_pkg::ScaleW-1:0]                scale_ff, scale_in;
   logic [nsdq_pkg::InvScaleW-1:0]             inv_ff, inv_in;
   logic [nsdq_pkg::SeedW-1:0]                 rng_ff, rng_in;
   logic signed [nsdq_pkg::StageW-1:0]         stage_ff [nsdq_pkg::NoiseStages];
   logic                                       stage_we;
   logic [nsdq_pkg::StageIdxW-1:0]             idx_ff, idx_in;
   logic signed [nsdq_pkg::SampleW-1:0]        sample_ff, sample_in;
   logic signed [nsdq_pkg::ScaleHiW-1:0]       hi_ff, hi_in;
   logic signed [nsdq_pkg::XW-1:0]             x_ff, x_in;
   logic signed [nsdq_pkg::StageW-1:0]         noise_ff, noise_in;
   logic signed [nsdq_pkg::ShaperW-1:0]        shaper_ff, shaper_in;
   logic signed [nsdq_pkg::ShaperW-1:0]        term_ff, term_in;
   logic signed [nsdq_pkg::ErrW-1:0]           err_ff, err_in;
   logic signed [nsdq_pkg::SumW-1:0]           sum_ff, sum_in;
   logic signed [nsdq_pkg::LevelW-1:0]         level_ff, level_in;
   logic signed [nsdq_pkg::ProdW-1:0]          prod_ff, prod_in;
   logic                                       rsp_valid_ff, rsp_valid_in;
   logic signed [nsdq_pkg::LevelW-1:0]         lvl_out_ff, lvl_out_in;
   logic signed [nsdq_pkg::SampleW-1:0]        out_ff, out_in;

   logic                                       mul_en;
   logic signed [nsdq_pkg::MulAW-1:0]          mul_a;
   logic signed [nsdq_pkg::MulBW-1:0]          mul_b;
   logic signed [nsdq_pkg::ProdW-1:0]          mul_p;

   logic [nsdq_pkg::SeedW-1:0]                 rng_next;
   logic signed [nsdq_pkg::StageW-1:0]         draw_next;
   logic                                       stage_last;
   logic signed [nsdq_pkg::StageW:0]           stage_sum;
   logic signed [nsdq_pkg::StageW-1:0]         stage_new;
   logic signed [nsdq_pkg::ScaleAccW-1:0]      scale_acc;
   logic signed [nsdq_pkg::ShaperW:0]          adj0, adj1;
   logic signed [nsdq_pkg::TermSumW-1:0]       term_wide;
   logic signed [nsdq_pkg::LevelRawW-1:0]      lvl_raw;
   logic signed [nsdq_pkg::SumW:0]             err_wide;
   logic signed [nsdq_pkg::ScaledW-1:0]        scaled;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level      = lvl_out_ff;
   assign rsp_sample_out = out_ff;

   assign mul_p      = mul_a * mul_b;
   assign rng_next   = rng_step(rng_ff);
   assign draw_next  = rng_draw(rng_next);
   assign stage_last = (idx_ff == nsdq_pkg::StageIdxW'(nsdq_pkg::NoiseStages - 1));
   assign stage_sum  = (nsdq_pkg::StageW + 1)'(stage_ff[idx_ff])
                     + (nsdq_pkg::StageW + 1)'(noise_ff);
   assign stage_new  = nsdq_pkg::StageW'(stage_sum >>> 1);
   assign scale_acc  = (nsdq_pkg::ScaleAccW'(hi_ff) <<< nsdq_pkg::ScaleHalfW)
                     + nsdq_pkg::ScaleAccW'(prod_ff);
   assign adj0 = (!shaper_ff[nsdq_pkg::ShaperW-1] && (shaper_ff != '0))
               ? (nsdq_pkg::ShaperW + 1)'(shaper_ff) - (nsdq_pkg::ShaperW + 1)'(nsdq_pkg::K097)
               : (nsdq_pkg::ShaperW + 1)'(shaper_ff);
   assign adj1 = adj0[nsdq_pkg::ShaperW]
               ? adj0 + (nsdq_pkg::ShaperW + 1)'(nsdq_pkg::K097) : adj0;
   assign term_wide = nsdq_pkg::TermSumW'(term_ff)
                    - nsdq_pkg::TermSumW'($signed(prod_ff[nsdq_pkg::FractionBits +:
                                                          nsdq_pkg::TermSumW]))
                    + nsdq_pkg::TermSumW'(err_ff);
   assign lvl_raw  = $signed(sum_ff[nsdq_pkg::SumW-1:nsdq_pkg::FractionBits]);
   assign err_wide = (nsdq_pkg::SumW + 1)'($signed({sum_ff[nsdq_pkg::SumW-1:nsdq_pkg::FractionBits],
                                                     {nsdq_pkg::FractionBits{1'b0}}}))
                   - (nsdq_pkg::SumW + 1)'(x_ff);
   assign scaled   = $signed(prod_ff[nsdq_pkg::ProdW-1:1]);

   always_comb begin
      state_in     = state_ff;
      scale_in     = scale_ff;
      inv_in       = inv_ff;
      rng_in       = rng_ff;
      idx_in       = idx_ff;
      sample_in    = sample_ff;
      hi_in        = hi_ff;
      x_in         = x_ff;
      noise_in     = noise_ff;
      shaper_in    = shaper_ff;
      term_in      = term_ff;
      err_in       = err_ff;
      sum_in       = sum_ff;
      level_in     = level_ff;
      lvl_out_in   = lvl_out_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      stage_we     = 1'b0;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample_in;
               rng_in    = rng_next;
               noise_in  = draw_next;
               idx_in    = '0;
               state_in  = ST_SCALE_HI;
            end
         end
         ST_SCALE_HI: begin
            mul_en   = 1'b1;
            mul_a    = nsdq_pkg::MulAW'(sample_ff);
            mul_b    = nsdq_pkg::MulBW'(scale_ff[nsdq_pkg::ScaleW-1 -: nsdq_pkg::ScaleHalfW]);
            state_in = ST_SCALE_LO;
         end
         ST_SCALE_LO: begin
            mul_en   = 1'b1;
            mul_a    = nsdq_pkg::MulAW'(sample_ff);
            mul_b    = nsdq_pkg::MulBW'(scale_ff[nsdq_pkg::ScaleHalfW-1:0]);
            hi_in    = nsdq_pkg::ScaleHiW'(prod_ff);
            state_in = ST_SCALE_SUM;
         end
         ST_SCALE_SUM: begin
            x_in     = nsdq_pkg::XW'(scale_acc >>> nsdq_pkg::ScaleShift);
            state_in = ST_DITHER;
         end
         ST_DITHER: begin
            rng_in   = rng_next;
            stage_we = 1'b1;
            if (stage_last) begin
               noise_in = noise_ff - stage_new;
               idx_in   = '0;
               state_in = ST_ADJUST;
            end else begin
               noise_in = noise_ff - stage_new + draw_next;
               idx_in   = nsdq_pkg::StageIdxW'(idx_ff + 1'b1);
            end
         end
         ST_ADJUST: begin
            rng_in   = rng_next;
            term_in  = nsdq_pkg::ShaperW'(adj1);
            sum_in   = nsdq_pkg::SumW'(noise_ff) + nsdq_pkg::SumW'(x_ff);
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            mul_en   = 1'b1;
            mul_a    = nsdq_pkg::MulAW'(term_ff);
            mul_b    = nsdq_pkg::MulBW'(term_ff);
            state_in = ST_CUBE;
         end
         ST_CUBE: begin
            mul_en   = 1'b1;
            mul_a    = nsdq_pkg::MulAW'(term_ff);
            mul_b    = nsdq_pkg::MulBW'($signed(prod_ff[nsdq_pkg::FractionBits +: nsdq_pkg::SqW]));
            state_in = ST_SOFTEN;
         end
         ST_SOFTEN: begin
            mul_en   = 1'b1;
            mul_a    = nsdq_pkg::MulAW'($signed(prod_ff[nsdq_pkg::FractionBits +:
                                                        nsdq_pkg::CubeW]));
            mul_b    = nsdq_pkg::MulBW'(nsdq_pkg::K0475);
            state_in = ST_SHAPER;
         end
         ST_SHAPER: begin
            if (&term_wide[nsdq_pkg::TermSumW-1:nsdq_pkg::ShaperW-1]
                || ~|term_wide[nsdq_pkg::TermSumW-1:nsdq_pkg::ShaperW-1]) begin
               shaper_in = term_wide[nsdq_pkg::ShaperW-1:0];
            end else if (term_wide[nsdq_pkg::TermSumW-1]) begin
               shaper_in = {1'b1, {(nsdq_pkg::ShaperW-1){1'b0}}};
            end else begin
               shaper_in = {1'b0, {(nsdq_pkg::ShaperW-1){1'b1}}};
            end
            term_in  = shaper_in;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            mul_en   = 1'b1;
            mul_a    = nsdq_pkg::MulAW'(term_ff);
            mul_b    = nsdq_pkg::MulBW'(nsdq_pkg::K0475);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in   = sum_ff + nsdq_pkg::SumW'($signed(prod_ff[nsdq_pkg::FractionBits +:
                                                                nsdq_pkg::ShaperW]));
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            if (&lvl_raw[nsdq_pkg::LevelRawW-1:nsdq_pkg::LevelW-1]
                || ~|lvl_raw[nsdq_pkg::LevelRawW-1:nsdq_pkg::LevelW-1]) begin
               level_in = lvl_raw[nsdq_pkg::LevelW-1:0];
            end else if (lvl_raw[nsdq_pkg::LevelRawW-1]) begin
               level_in = {1'b1, {(nsdq_pkg::LevelW-1){1'b0}}};
            end else begin
               level_in = {1'b0, {(nsdq_pkg::LevelW-1){1'b1}}};
            end
            if (&err_wide[nsdq_pkg::SumW:nsdq_pkg::ErrW-1]
                || ~|err_wide[nsdq_pkg::SumW:nsdq_pkg::ErrW-1]) begin
               err_in = err_wide[nsdq_pkg::ErrW-1:0];
            end else if (err_wide[nsdq_pkg::SumW]) begin
               err_in = {1'b1, {(nsdq_pkg::ErrW-1){1'b0}}};
            end else begin
               err_in = {1'b0, {(nsdq_pkg::ErrW-1){1'b1}}};
            end
            state_in = ST_RESCALE;
         end
         ST_RESCALE: begin
            mul_en   = 1'b1;
            mul_a    = nsdq_pkg::MulAW'(level_ff);
            mul_b    = nsdq_pkg::MulBW'(inv_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               lvl_out_in   = level_ff;
               if (&scaled[nsdq_pkg::ScaledW-1:nsdq_pkg::SampleW-1]
                   || ~|scaled[nsdq_pkg::ScaledW-1:nsdq_pkg::SampleW-1]) begin
                  out_in = scaled[nsdq_pkg::SampleW-1:0];
               end else if (scaled[nsdq_pkg::ScaledW-1]) begin
                  out_in = {1'b1, {(nsdq_pkg::SampleW-1){1'b0}}};
               end else begin
                  out_in = {1'b0, {(nsdq_pkg::SampleW-1){1'b1}}};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            nsdq_pkg::CsrScale: begin
               scale_in = csr_wdata[nsdq_pkg::ScaleW-1:0];
            end
            nsdq_pkg::CsrInvScale: begin
               inv_in = csr_wdata[nsdq_pkg::InvScaleW-1:0];
            end
            nsdq_pkg::CsrSeed: begin
               rng_in = (csr_wdata[nsdq_pkg::SeedW-1:0] == '0) ? nsdq_pkg::SeedDefault
                                                              : csr_wdata[nsdq_pkg::SeedW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign prod_in = mul_en ? mul_p : prod_ff;

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      hi_ff      <= hi_in;
      x_ff       <= x_in;
      noise_ff   <= noise_in;
      term_ff    <= term_in;
      sum_ff     <= sum_in;
      level_ff   <= level_in;
      prod_ff    <= prod_in;
      lvl_out_ff <= lvl_out_in;
      out_ff     <= out_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         scale_ff     <= nsdq_pkg::ScaleReset;
         inv_ff       <= nsdq_pkg::InvScaleReset;
         rng_ff       <= nsdq_pkg::SeedDefault;
         shaper_ff    <= '0;
         err_ff       <= '0;
         for (int i = 0; i < nsdq_pkg::NoiseStages; i++) begin
            stage_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         scale_ff     <= scale_in;
         inv_ff       <= inv_in;
         rng_ff       <= rng_in;
         shaper_ff    <= shaper_in;
         err_ff       <= err_in;
         if (stage_we) begin
            stage_ff[idx_ff] <= stage_new;
         end
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("Unit took a new beat while a sample was in progress.");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("Result beat appeared outside the final step.");

   a_rng_nonzero: assert property (@(posedge clock) disable iff (reset)
      rng_ff != '0)
      else $error("Generator word reached zero.");

   a_output_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_level[nsdq_pkg::LevelW-1]) |-> !rsp_sample_out[nsdq_pkg::SampleW-1])
      else $error("Rescaled sample is negative for a nonnegative level.");

   a_stage_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DITHER && !stage_last) |=>
         (state_ff == ST_DITHER
          && idx_ff == nsdq_pkg::StageIdxW'($past(idx_ff) + 1'b1)))
      else $error("Noise cascade skipped or repeated a stage.");

endmodule

/* tb/sv/noise_shaped_dither_quantizer_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts every result beat of the noise-shaped dither quantizer and compares it.
module noise_shaped_dither_quantizer_checker
   import nsdq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic signed [SampleW-1:0]   req_sample_in,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic signed [LevelW-1:0]    rsp_level,
   input  logic signed [SampleW-1:0]   rsp_sample_out,
   input  logic                        csr_we,
   input  logic [CsrIndexW-1:0]        csr_index,
   input  logic [CsrDataW-1:0]         csr_wdata,
   output int unsigned                 fail_count,
   output int unsigned                 outstanding
);

   localparam longint Step097   = (longint'(97) <<< FractionBits) / 100;
   localparam longint Mix0475   = (longint'(19) <<< FractionBits) / 40;
   localparam longint ShaperLim = longint'(1) <<< (FractionBits + 3);
   localparam longint ErrorLim  = longint'(1) <<< (FractionBits + 4);
   localparam longint LevelLim  = longint'(1) <<< (LevelW - 1);
   localparam longint SampleLim = longint'(1) <<< (SampleW - 1);

   typedef struct packed {
      logic [LevelW-1:0]  level;
      logic [SampleW-1:0] sample_out;
   } quant_beat_type;

   logic [ScaleW-1:0]    gain;
   logic [InvScaleW-1:0] inv_scale;
   logic [SeedW-1:0]     dither_word;
   longint               cascade [NoiseStages];
   longint               odd_term;
   longint               quant_error;
   quant_beat_type       owed_beats [$];
   int unsigned          mismatches = 0;

   function automatic longint saturate(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Fixed-point product a * b / 2^F, rounded toward minus infinity.
   function automatic longint frac_product(input longint a, input longint b);
      longint lo;
      longint hi;
      lo = b & 64'hFFFF;
      hi = b >>> 16;
      return (a * hi + ((a * lo) >>> 16)) >>> (FractionBits - 16);
   endfunction

   function automatic logic [SeedW-1:0] next_dither(input logic [SeedW-1:0] w);
      logic [SeedW-1:0] v;
      v = w;
      v = v ^ (v << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

   function automatic longint dither_draw(input logic [SeedW-1:0] w);
      return longint'(w[31:32-FractionBits]) - (longint'(1) <<< (FractionBits - 1));
   endfunction

   function automatic quant_beat_type quantize_sample(input logic signed [SampleW-1:0] smp);
      longint         s;
      longint         x;
      longint         noise;
      longint         term;
      longint         sum;
      longint         lvl;
      longint         o;
      longint         sq;
      longint         cube;
      quant_beat_type beat;
      s = longint'(smp);
      dither_word = next_dither(dither_word);
      x = 2 * (s * longint'(gain[ScaleW-1:ScaleHalfW]))
          + ((s * longint'(gain[ScaleHalfW-1:0])) >>> 23);
      x = x >>> (32 - FractionBits);
      noise = dither_draw(dither_word);
      for (int i = 0; i < NoiseStages; i++) begin
         dither_word = next_dither(dither_word);
         cascade[i] = (cascade[i] + noise) >>> 1;
         noise = noise - cascade[i];
         if (i < NoiseStages - 1)
            noise = noise + dither_draw(dither_word);
      end
      dither_word = next_dither(dither_word);
      sum = noise + x;

      term = odd_term;
      if (term > 0)
         term = term - Step097;
      if (term < 0)
         term = term + Step097;
      sq = frac_product(term, term);
      cube = frac_product(term, sq);
      term = term - frac_product(cube, Mix0475);
      term = saturate(term + quant_error, -ShaperLim, ShaperLim - 1);
      odd_term = term;
      sum = sum + frac_product(term, Mix0475);

      lvl = sum >>> FractionBits;
      quant_error = saturate((lvl <<< FractionBits) - x, -ErrorLim, ErrorLim - 1);
      lvl = saturate(lvl, -LevelLim, LevelLim - 1);
      o = saturate((lvl * longint'(inv_scale)) >>> 1, -SampleLim, SampleLim - 1);
      beat.level = lvl[LevelW-1:0];
      beat.sample_out = o[SampleW-1:0];
      return beat;
   endfunction

   always @(posedge clock) begin
      quant_beat_type want;
      if (reset) begin
         gain = ScaleReset;
         inv_scale = InvScaleReset;
         dither_word = SeedDefault;
         for (int i = 0; i < NoiseStages; i++)
            cascade[i] = 0;
         odd_term = 0;
         quant_error = 0;
         owed_beats.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrScale:    gain = csr_wdata[ScaleW-1:0];
               CsrInvScale: inv_scale = csr_wdata[InvScaleW-1:0];
               CsrSeed: begin
                  dither_word = (csr_wdata[SeedW-1:0] == '0) ? SeedDefault
                                                             : csr_wdata[SeedW-1:0];
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_beats.size() == 0) begin
               mismatches++;
               $error("result beat with no sample outstanding: level %0d, sample_out %0d",
                      rsp_level, rsp_sample_out);
            end else begin
               want = owed_beats.pop_front();
               if (rsp_level !== want.level) begin
                  mismatches++;
                  $error("level mismatch: expected %0d, actual %0d",
                         $signed(want.level), rsp_level);
               end
               if (rsp_sample_out !== want.sample_out) begin
                  mismatches++;
                  $error("sample_out mismatch: expected %0d, actual %0d",
                         $signed(want.sample_out), rsp_sample_out);
               end
            end
         end
         if (req_valid && req_ready)
            owed_beats.push_back(quantize_sample(req_sample_in));
      end
      outstanding <= owed_beats.size();
      fail_count <= mismatches;
   end

endmodule

/* tb/sv/noise_shaped_dither_quantizer_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the noise-shaped dither quantizer: stimulus, register phases and verdict.
module noise_shaped_dither_quantizer_unit_tb;
   import nsdq_pkg::*;

   localparam int PhaseCount     = 9;
   localparam int RandomPerPhase = 152;
   localparam int CornerCount    = 12;
   localparam logic [CsrIndexW-1:0] CsrSpare = 2'd3;

   typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [SampleW-1:0] req_sample_in = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [LevelW-1:0]  rsp_level;
   logic signed [SampleW-1:0] rsp_sample_out;
   logic                      csr_we = 1'b0;
   logic [CsrIndexW-1:0]      csr_index = '0;
   logic [CsrDataW-1:0]       csr_wdata = '0;
   int unsigned               fail_count;
   int unsigned               outstanding;
   int                        sender_idle_pct = 0;
   int                        receiver_stall_pct = 0;

   noise_shaped_dither_quantizer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level      (rsp_level),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   noise_shaped_dither_quantizer_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level      (rsp_level),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   function automatic logic [SampleW-1:0] corner_sample(input int k);
      case (k)
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return 32'h0000_0001;
         5:       return 32'h4000_0000;
         6:       return 32'hC000_0000;
         7:       return 32'h0001_0000;
         8:       return 32'hFFFF_0000;
         9:       return 32'h5555_5555;
         10:      return 32'hAAAA_AAAA;
         default: return 32'h7FFF_FFFE;
      endcase
   endfunction

   // Mixes full-scale noise, quiet signals, clipped rails and held levels that
   // let the shaper feedback build up.
   function automatic logic [SampleW-1:0] next_sample(input logic [SampleW-1:0] prev);
      case ($urandom_range(4))
         0:       return $urandom;
         1:       return $signed($urandom) >>> $urandom_range(31);
         2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return prev;
      endcase
   endfunction

   function automatic logic [ScaleW-1:0] random_gain();
      logic [63:0] r;
      r = {$urandom, $urandom} >> $urandom_range(17, 53);
      if (r < 64'd1678)
         r = 64'd1678;
      return r[ScaleW-1:0];
   endfunction

   function automatic logic [InvScaleW-1:0] random_inv_scale();
      logic [31:0] r;
      r = $urandom >> $urandom_range(3, 22);
      if (r < 32'd512)
         r = 32'd512;
      return r[InvScaleW-1:0];
   endfunction

   function automatic logic [SeedW-1:0] random_seed();
      logic [31:0] r;
      r = $urandom;
      if (r < 32'd16386)
         r = r + 32'd16386;
      return r;
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IdleSender: begin
            sender_idle_pct = 69;
            receiver_stall_pct = 0;
         end
         IdleReceiver: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 69;
         end
         IdleBoth: begin
            sender_idle_pct = 20;
            receiver_stall_pct = 20;
         end
         default: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
      endcase
   endtask

   task automatic send_sample(input logic [SampleW-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // The caller lowers csr_we once its batch of writes is done.
   task automatic write_register(input logic [CsrIndexW-1:0] index,
                                 input logic [CsrDataW-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   initial begin
      logic [SampleW-1:0] held;
      held = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < PhaseCount; phase++) begin
         if (phase > 0) begin
            drain();
            case (phase)
               1: begin
                  write_register(CsrScale, 48'h8000_0000_0000);
                  write_register(CsrInvScale, 48'h2000_0000);
                  write_register(CsrSeed, 48'h0);
                  write_register(CsrSpare, CsrDataW'({$urandom, $urandom}));
               end
               2: begin
                  write_register(CsrScale, 48'd1678);
                  write_register(CsrInvScale, 48'd512);
                  write_register(CsrSeed, 48'hFFFF_FFFF);
               end
               3: begin
                  write_register(CsrScale, 48'hFFFF_FFFF_FFFF);
                  write_register(CsrInvScale, 48'h3FFF_FFFF);
                  write_register(CsrSeed, 48'd16386);
               end
               default: begin
                  write_register(CsrScale, random_gain());
                  write_register(CsrInvScale, CsrDataW'(random_inv_scale()));
                  write_register(CsrSeed, CsrDataW'(random_seed()));
               end
            endcase
            csr_we <= 1'b0;
         end
         set_idling(IdleNone);
         if (phase < 2) begin
            for (int k = 0; k < CornerCount; k++)
               send_sample(corner_sample(k));
         end
         set_idling(idle_mode_type'(phase % 4));
         for (int n = 0; n < RandomPerPhase; n++) begin
            held = next_sample(held);
            send_sample(held);
         end
      end
      drain();
      repeat (2 * NoiseStages + 8) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
